[rtl/nrgks_pkg.sv]
// shared types, codes and defaults for the greedy no-repeat kind scheduler
`default_nettype none

package nrgks_pkg;

  // default sizes
  localparam int unsigned MAX_KINDS_DEF   = 256;
  localparam int unsigned COUNT_WIDTH_DEF = 20;

  // op codes of an input word
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_NEXT  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  // status codes of a result word
  typedef enum logic [1:0] {
    STAT_PLACED = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_STUCK  = 2'd2,
    STAT_DONE   = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_RESP
  } fsm_e;

  // input word
  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  kind_index;
    logic [19:0] count_value;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [7:0] chosen_kind;
    logic [1:0] status;
  } out_word_t;

  // control into the pick unit
  typedef struct packed {
    logic init;
    logic sample;
  } pick_ctl_t;

  // status out of the pick unit
  typedef struct packed {
    logic found;
    logic any;
  } pick_stat_t;

endpackage

`default_nettype wire

[rtl/nrgks_pick.sv]
// compare and track unit: keeps the largest eligible count seen during a scan
`default_nettype none

module nrgks_pick #(
  parameter int unsigned IDX_W   = 8,
  parameter int unsigned COUNT_W = 20
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  nrgks_pkg::pick_ctl_t      ctl_i,
  input  wire  [IDX_W-1:0]          idx_i,
  input  wire  [COUNT_W-1:0]        cnt_i,
  input  wire                       last_valid_i,
  input  wire  [IDX_W-1:0]          last_kind_i,
  output nrgks_pkg::pick_stat_t     stat_o,
  output logic [IDX_W-1:0]          best_idx_o,
  output logic [COUNT_W-1:0]        best_cnt_o
);

  logic               found_q, found_d;
  logic               any_q, any_d;
  logic [IDX_W-1:0]   best_idx_q, best_idx_d;
  logic [COUNT_W-1:0] best_cnt_q, best_cnt_d;
  logic               nonzero;
  logic               eligible;
  logic               take;

  // eligibility and the single compare, ties go to the later (higher) index
  always_comb begin
    nonzero  = (cnt_i != '0);
    eligible = nonzero && !(last_valid_i && (idx_i == last_kind_i));
    take     = ctl_i.sample && eligible && (!found_q || (cnt_i >= best_cnt_q));
    found_d    = found_q;
    any_d      = any_q;
    best_idx_d = best_idx_q;
    best_cnt_d = best_cnt_q;
    if (ctl_i.init) begin
      found_d = 1'b0;
      any_d   = 1'b0;
    end else begin
      if (ctl_i.sample && nonzero) begin
        any_d = 1'b1;
      end
      if (take) begin
        found_d    = 1'b1;
        best_idx_d = idx_i;
        best_cnt_d = cnt_i;
      end
    end
  end

  // flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      any_q   <= 1'b0;
    end else begin
      found_q <= found_d;
      any_q   <= any_d;
    end
  end

  // best candidate payload
  always_ff @(posedge clk_i) begin
    best_idx_q <= best_idx_d;
    best_cnt_q <= best_cnt_d;
  end

  assign stat_o.found = found_q;
  assign stat_o.any   = any_q;
  assign best_idx_o   = best_idx_q;
  assign best_cnt_o   = best_cnt_q;

endmodule

`default_nettype wire

[rtl/no_repeat_greedy_kind_scheduler.sv]
// Greedy no-repeat kind scheduler: per-kind count memory scanned by one compare unit.
// Next word: a scan reads every count, one count read per cycle, before the result is formed.
// Clear word: a zeroing sweep writes one entry per cycle; load and unused ops go straight
// to the response state. One word is in work at a time; a result waiting in the output
// register does not hold off the next input word. After reset a zeroing sweep of all
// MAX_KINDS entries runs before the first word is accepted.
`default_nettype none

module no_repeat_greedy_kind_scheduler #(
  parameter int unsigned MAX_KINDS   = nrgks_pkg::MAX_KINDS_DEF,
  parameter int unsigned COUNT_WIDTH = nrgks_pkg::COUNT_WIDTH_DEF
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  nrgks_pkg::in_word_t  in_word_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output nrgks_pkg::out_word_t out_word_o
);

  localparam int unsigned IDX_W = (MAX_KINDS > 1) ? $clog2(MAX_KINDS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_KINDS - 1);

  // count memory
  logic [COUNT_WIDTH-1:0] mem [MAX_KINDS];
  logic                   we;
  logic [IDX_W-1:0]       wa;
  logic [COUNT_WIDTH-1:0] wd;
  logic                   re;
  logic [COUNT_WIDTH-1:0] rd_data_q;
  logic                   rd_vld_q;
  logic [IDX_W-1:0]       rd_idx_q;

  nrgks_pkg::fsm_e        state_q, state_d;
  logic [IDX_W-1:0]       addr_q, addr_d;
  logic                   clr_resp_q, clr_resp_d;
  logic [IDX_W-1:0]       last_kind_q, last_kind_d;
  logic                   last_valid_q, last_valid_d;
  nrgks_pkg::op_e         op_q, op_d;
  logic                   out_valid_q, out_valid_d;
  nrgks_pkg::out_word_t   out_word_q, out_word_d;

  logic                   accept;
  logic                   out_free;
  logic                   in_range;
  nrgks_pkg::op_e         in_op;
  nrgks_pkg::pick_ctl_t   pick_ctl;
  nrgks_pkg::pick_stat_t  pick_stat;
  logic [IDX_W-1:0]       best_idx;
  logic [COUNT_WIDTH-1:0] best_cnt;

  assign in_op    = nrgks_pkg::op_e'(in_word_i.op);
  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_range = (32'(in_word_i.kind_index) < 32'(MAX_KINDS));

  // sequencer
  always_comb begin
    state_d      = state_q;
    addr_d       = addr_q;
    clr_resp_d   = clr_resp_q;
    last_kind_d  = last_kind_q;
    last_valid_d = last_valid_q;
    op_d         = op_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_word_d   = out_word_q;
    we           = 1'b0;
    wa           = addr_q;
    wd           = '0;
    re           = 1'b0;
    pick_ctl     = '0;
    in_stall_o   = (state_q != nrgks_pkg::S_IDLE);

    unique case (state_q)
      nrgks_pkg::S_CLEAR: begin
        we = 1'b1;
        wa = addr_q;
        wd = '0;
        addr_d = addr_q + 1'b1;
        if (addr_q == LAST_IDX) begin
          addr_d  = '0;
          state_d = clr_resp_q ? nrgks_pkg::S_RESP : nrgks_pkg::S_IDLE;
        end
      end
      nrgks_pkg::S_IDLE: begin
        if (accept) begin
          op_d = in_op;
          unique case (in_op)
            nrgks_pkg::OP_LOAD: begin
              we = in_range;
              wa = IDX_W'(in_word_i.kind_index);
              wd = COUNT_WIDTH'(in_word_i.count_value);
              state_d = nrgks_pkg::S_RESP;
            end
            nrgks_pkg::OP_NEXT: begin
              pick_ctl.init = 1'b1;
              addr_d  = '0;
              state_d = nrgks_pkg::S_SCAN;
            end
            nrgks_pkg::OP_CLEAR: begin
              last_kind_d  = '0;
              last_valid_d = 1'b0;
              clr_resp_d   = 1'b1;
              addr_d       = '0;
              state_d      = nrgks_pkg::S_CLEAR;
            end
            default: begin
              state_d = nrgks_pkg::S_RESP;
            end
          endcase
        end
      end
      nrgks_pkg::S_SCAN: begin
        re = 1'b1;
        pick_ctl.sample = rd_vld_q;
        addr_d = addr_q + 1'b1;
        if (addr_q == LAST_IDX) begin
          addr_d  = '0;
          state_d = nrgks_pkg::S_LAST;
        end
      end
      nrgks_pkg::S_LAST: begin
        pick_ctl.sample = rd_vld_q;
        state_d = nrgks_pkg::S_RESP;
      end
      nrgks_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_d            = 1'b1;
          out_word_d.chosen_kind = '0;
          out_word_d.status      = nrgks_pkg::STAT_DONE;
          clr_resp_d             = 1'b0;
          if (op_q == nrgks_pkg::OP_NEXT) begin
            if (pick_stat.found) begin
              we = 1'b1;
              wa = best_idx;
              wd = best_cnt - COUNT_WIDTH'(1);
              last_kind_d            = best_idx;
              last_valid_d           = 1'b1;
              out_word_d.chosen_kind = 8'(best_idx);
              out_word_d.status      = nrgks_pkg::STAT_PLACED;
            end else if (pick_stat.any) begin
              out_word_d.status = nrgks_pkg::STAT_STUCK;
            end else begin
              out_word_d.status = nrgks_pkg::STAT_EMPTY;
            end
          end
          state_d = nrgks_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = nrgks_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= nrgks_pkg::S_CLEAR;
      addr_q       <= '0;
      clr_resp_q   <= 1'b0;
      last_kind_q  <= '0;
      last_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      rd_vld_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      addr_q       <= addr_d;
      clr_resp_q   <= clr_resp_d;
      last_kind_q  <= last_kind_d;
      last_valid_q <= last_valid_d;
      out_valid_q  <= out_valid_d;
      rd_vld_q     <= re;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    out_word_q <= out_word_d;
    rd_idx_q   <= addr_q;
  end

  // count memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data_q <= mem[addr_q];
    end
  end

  // shared compare unit
  nrgks_pick #(
    .IDX_W   (IDX_W),
    .COUNT_W (COUNT_WIDTH)
  ) u_pick (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (pick_ctl),
    .idx_i        (rd_idx_q),
    .cnt_i        (rd_data_q),
    .last_valid_i (last_valid_q),
    .last_kind_i  (last_kind_q),
    .stat_o       (pick_stat),
    .best_idx_o   (best_idx),
    .best_cnt_o   (best_cnt)
  );

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // a placement never repeats the kind placed last
  a_no_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == nrgks_pkg::S_RESP && out_free && op_q == nrgks_pkg::OP_NEXT &&
     pick_stat.found && last_valid_q) |-> (best_idx != last_kind_q))
    else $error("placed kind equals last kind");

  // a placed kind had a count above zero
  a_nonzero_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == nrgks_pkg::S_RESP && pick_stat.found) |-> (best_cnt != '0))
    else $error("picked kind with zero count");

  // a found candidate implies some count was nonzero
  a_found_any: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pick_stat.found |-> pick_stat.any)
    else $error("found without any nonzero count");

  // read data only arrives in the cycle after a scan read
  a_read_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == nrgks_pkg::S_SCAN || state_q == nrgks_pkg::S_LAST))
    else $error("read data outside scan");

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// self-checking testbench for the greedy no-repeat kind scheduler
`default_nettype none

module tb_top;
  import nrgks_pkg::*;

  localparam int unsigned N_KINDS     = MAX_KINDS_DEF;
  localparam int unsigned CNT_W       = COUNT_WIDTH_DEF;
  localparam int unsigned RANDOM_WORDS = 550;
  localparam int unsigned DRAIN_CYCLES = N_KINDS + 40;
  localparam int unsigned IDLE_LIMIT   = 4000;

  // one row of the directed plan
  typedef struct {
    in_word_t  word;
    bit        has_res;
    out_word_t res;
  } plan_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  // predictor state
  logic [CNT_W-1:0] kind_left [N_KINDS];
  logic [7:0]       prev_kind;
  logic             prev_valid;

  out_word_t   pending_results [$];
  plan_row_t   plan [$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit          calm = 1'b0;

  no_repeat_greedy_kind_scheduler dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // expected result of one word; updates the predictor state
  function automatic out_word_t schedule_word(input in_word_t w);
    out_word_t        r;
    logic             found;
    logic             any;
    int unsigned      best;
    logic [CNT_W-1:0] best_cnt;
    r.chosen_kind = '0;
    r.status      = STAT_DONE;
    found         = 1'b0;
    any           = 1'b0;
    best          = 0;
    best_cnt      = '0;
    case (w.op)
      OP_LOAD: begin
        if (w.kind_index < N_KINDS) kind_left[w.kind_index] = w.count_value[CNT_W-1:0];
      end
      OP_CLEAR: begin
        for (int i = 0; i < N_KINDS; i++) kind_left[i] = '0;
        prev_kind  = '0;
        prev_valid = 1'b0;
      end
      OP_NEXT: begin
        // ascending scan, ties go to the higher kind
        for (int i = 0; i < N_KINDS; i++) begin
          if (kind_left[i] != '0) begin
            any = 1'b1;
            if (!(prev_valid && i == prev_kind) && (!found || kind_left[i] >= best_cnt)) begin
              found    = 1'b1;
              best     = i;
              best_cnt = kind_left[i];
            end
          end
        end
        if (found) begin
          kind_left[best] = best_cnt - 1'b1;
          prev_kind       = best[7:0];
          prev_valid      = 1'b1;
          r.chosen_kind   = best[7:0];
          r.status        = STAT_PLACED;
        end else if (any) begin
          r.status = STAT_STUCK;
        end else begin
          r.status = STAT_EMPTY;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // gap length: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic plan_row_t mk_row(input op_e op, input logic [7:0] kind,
                                       input logic [19:0] cnt, input bit has_res,
                                       input logic [7:0] res_kind, input status_e res_stat);
    plan_row_t row;
    row.word.op          = op;
    row.word.kind_index  = kind;
    row.word.count_value = cnt;
    row.has_res          = has_res;
    row.res.chosen_kind  = res_kind;
    row.res.status       = res_stat;
    return row;
  endfunction

  // drive one word from a falling edge and wait for it to be taken
  task automatic send_word(input in_word_t w, input bit has_res, input out_word_t res);
    out_word_t     p;
    int unsigned   gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      in_word  = in_word_t'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    in_word  = w;
    in_valid = 1'b1;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    p = schedule_word(w);
    pending_results.push_back(has_res ? res : p);
    @(negedge clk_i);
  endtask

  task automatic send_op(input op_e op, input logic [7:0] kind, input logic [19:0] cnt,
                         inout int unsigned sent);
    in_word_t  w;
    out_word_t none;
    w.op          = op;
    w.kind_index  = kind;
    w.count_value = cnt;
    none          = '0;
    send_word(w, 1'b0, none);
    sent++;
  endtask

  // well-formed batch: an optional clear, loads of a few kinds, then a run of next words
  task automatic run_batch(inout int unsigned sent);
    int unsigned nk;
    int unsigned nn;
    logic [19:0] cnt;
    if ($urandom_range(0, 1) == 1) send_op(OP_CLEAR, 8'($urandom), 20'($urandom), sent);
    nk = $urandom_range(1, 5);
    repeat (nk) begin
      cnt = ($urandom_range(0, 7) == 0) ? 20'($urandom) : 20'($urandom_range(0, 4));
      send_op(OP_LOAD, 8'($urandom), cnt, sent);
    end
    nn = $urandom_range(2, 20);
    repeat (nn) send_op(OP_NEXT, 8'($urandom), 20'($urandom), sent);
  endtask

  // noise: any op with random fields
  task automatic run_noise(inout int unsigned sent);
    repeat ($urandom_range(1, 4))
      send_op(op_e'($urandom_range(0, 3)), 8'($urandom), 20'($urandom), sent);
  endtask

  // receiver stalls
  initial begin
    int unsigned n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      n = pick_gap();
      if (n == 0) begin
        out_stall = 1'b0;
      end else begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk_i);
        out_stall = 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word kind %0d status %0d", $time,
                 out_word.chosen_kind, out_word.status);
        mismatches++;
      end else begin
        exp_w = pending_results.pop_front();
        if (out_word.status !== exp_w.status) begin
          $display("%0t: status expected %0d got %0d", $time, exp_w.status, out_word.status);
          mismatches++;
        end
        if (out_word.chosen_kind !== exp_w.chosen_kind) begin
          $display("%0t: chosen_kind expected %0d got %0d", $time,
                   exp_w.chosen_kind, out_word.chosen_kind);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted word or taken result
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    int unsigned sent;
    int unsigned stop_at;
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    in_word    = '0;
    prev_kind  = '0;
    prev_valid = 1'b0;
    sent       = 0;
    for (int i = 0; i < N_KINDS; i++) kind_left[i] = '0;

    // directed plan: extremes, ties, stuck and empty cases
    plan.push_back(mk_row(OP_NEXT,  8'h00, 20'h00000, 1'b1, 8'h00, STAT_EMPTY));
    plan.push_back(mk_row(OP_NOP,   8'hff, 20'hfffff, 1'b1, 8'h00, STAT_DONE));
    plan.push_back(mk_row(OP_LOAD,  8'hff, 20'hfffff, 1'b1, 8'h00, STAT_DONE));
    plan.push_back(mk_row(OP_LOAD,  8'h00, 20'h00001, 1'b1, 8'h00, STAT_DONE));
    plan.push_back(mk_row(OP_NEXT,  8'h00, 20'h00000, 1'b1, 8'hff, STAT_PLACED));
    plan.push_back(mk_row(OP_NEXT,  8'hff, 20'hfffff, 1'b1, 8'h00, STAT_PLACED));
    plan.push_back(mk_row(OP_NEXT,  8'h00, 20'h00000, 1'b1, 8'hff, STAT_PLACED));
    plan.push_back(mk_row(OP_NEXT,  8'h00, 20'h00000, 1'b1, 8'h00, STAT_STUCK));
    plan.push_back(mk_row(OP_NOP,   8'h00, 20'h00000, 1'b1, 8'h00, STAT_DONE));
    plan.push_back(mk_row(OP_CLEAR, 8'hff, 20'hfffff, 1'b1, 8'h00, STAT_DONE));
    plan.push_back(mk_row(OP_NEXT,  8'h00, 20'h00000, 1'b1, 8'h00, STAT_EMPTY));
    plan.push_back(mk_row(OP_LOAD,  8'h05, 20'h00003, 1'b0, 8'h00, STAT_DONE));
    plan.push_back(mk_row(OP_LOAD,  8'h09, 20'h00003, 1'b0, 8'h00, STAT_DONE));
    plan.push_back(mk_row(OP_NEXT,  8'h00, 20'h00000, 1'b0, 8'h00, STAT_DONE));
    plan.push_back(mk_row(OP_NEXT,  8'h00, 20'h00000, 1'b0, 8'h00, STAT_DONE));
    plan.push_back(mk_row(OP_LOAD,  8'haa, 20'h55555, 1'b0, 8'h00, STAT_DONE));
    plan.push_back(mk_row(OP_LOAD,  8'h55, 20'haaaaa, 1'b0, 8'h00, STAT_DONE));
    plan.push_back(mk_row(OP_NEXT,  8'h55, 20'haaaaa, 1'b0, 8'h00, STAT_DONE));
    plan.push_back(mk_row(OP_NEXT,  8'haa, 20'h55555, 1'b0, 8'h00, STAT_DONE));
    plan.push_back(mk_row(OP_LOAD,  8'haa, 20'h00000, 1'b0, 8'h00, STAT_DONE));
    plan.push_back(mk_row(OP_LOAD,  8'h55, 20'h00000, 1'b0, 8'h00, STAT_DONE));
    plan.push_back(mk_row(OP_NEXT,  8'h00, 20'h00000, 1'b0, 8'h00, STAT_DONE));
    plan.push_back(mk_row(OP_NEXT,  8'h00, 20'h00000, 1'b0, 8'h00, STAT_DONE));
    plan.push_back(mk_row(OP_CLEAR, 8'h00, 20'h00000, 1'b0, 8'h00, STAT_DONE));
    plan.push_back(mk_row(OP_NEXT,  8'h00, 20'h00000, 1'b1, 8'h00, STAT_EMPTY));

    // reset
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[i]) send_word(plan[i].word, plan[i].has_res, plan[i].res);

    // random part: mostly well-formed batches, some noise
    stop_at = sent + RANDOM_WORDS;
    while (sent < stop_at) begin
      if ($urandom_range(0, 7) == 0) calm = !calm;
      if ($urandom_range(0, 3) != 0) run_batch(sent);
      else run_noise(sent);
    end
    in_valid = 1'b0;
    calm     = 1'b0;

    // drain
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

[no_repeat_greedy_kind_scheduler.f]
rtl/nrgks_pkg.sv
rtl/nrgks_pick.sv
rtl/no_repeat_greedy_kind_scheduler.sv
tb/sv/tb_top.sv
